### src/pmm_pkg.sv
package pmm_pkg;

  localparam int CMD_W    = 3;
  localparam int PID_W    = 4;
  localparam int BCNT_W   = 15;
  localparam int ADDR_W   = 14;
  localparam int DATA_W   = 8;
  localparam int STATUS_W = 2;
  localparam int HELD_W   = 7;
  localparam int PS_W     = 9;

  localparam logic [PS_W-1:0] PS_RESET = 9'd32;

  localparam logic [CMD_W-1:0] CMD_CREATE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RESIZE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DESTROY = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_WRITE   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_COPY    = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OOM     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_PROC = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NO_PAGE = 2'd3;

endpackage

### src/paged_process_memory_manager_core.sv
// Channel   | Ports                                   | Handshake
// ----------+-----------------------------------------+-------------------------------
// command   | in_cmd .. in_write_data                 | taken when start & !busy
// result    | out_status, out_read_data, out_pages_.. | out_strobe, one cycle, no stall
// config    | cfg_wdata                               | written when cfg_we
//
// One command at a time; busy stays high until its result beat has gone. Create, unknown
// commands and empty slots go straight from dispatch to the result beat; a divide makes
// one quotient bit a cycle, NW = 15 bits by default. Resize: a divide, then frames scanned
// or pages freed, then the page count written back; destroy frees pages; access: two divides
// each, with a page-table search between them (a copy locates both sides).
// After reset the frame map is cleared, one entry a cycle; the receiver never stalls.
module paged_process_memory_manager_core import pmm_pkg::*; #(
  parameter int FRAMES         = 64,
  parameter int PROCESSES      = 16,
  parameter int MAX_PAGE_BYTES = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic [PID_W-1:0]    in_process_id,
  input  logic [BCNT_W-1:0]   in_byte_count,
  input  logic [ADDR_W-1:0]   in_address,
  input  logic [ADDR_W-1:0]   in_source_address,
  input  logic [ADDR_W-1:0]   in_byte_index,
  input  logic [DATA_W-1:0]   in_write_data,
  output logic                out_strobe,
  output logic [STATUS_W-1:0] out_status,
  output logic [DATA_W-1:0]   out_read_data,
  output logic [HELD_W-1:0]   out_pages_held,
  input  logic                cfg_we,
  input  logic [PS_W-1:0]     cfg_wdata
);

  localparam int FW   = $clog2(FRAMES);
  localparam int CW   = $clog2(FRAMES + 1);
  localparam int PIW  = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
  localparam int PTD  = PROCESSES * FRAMES;
  localparam int PTAW = $clog2(PTD);
  localparam int DD   = FRAMES * MAX_PAGE_BYTES;
  localparam int PHW  = $clog2(DD);
  localparam int PSW  = $clog2(MAX_PAGE_BYTES + 1);
  localparam int DIVW = $clog2(DD + 16384);

  typedef enum logic [15:0] {
    S_CLR    = 16'h0001,
    S_IDLE   = 16'h0002,
    S_DISP   = 16'h0004,
    S_RDIV   = 16'h0008,
    S_GSCAN  = 16'h0010,
    S_GCHK   = 16'h0020,
    S_SHRINK = 16'h0040,
    S_SFREE  = 16'h0080,
    S_WB     = 16'h0100,
    S_LDIV1  = 16'h0200,
    S_LSRCH  = 16'h0400,
    S_LCMP   = 16'h0800,
    S_LDIV2  = 16'h1000,
    S_LFRM   = 16'h2000,
    S_DRD    = 16'h4000,
    S_DONE   = 16'h8000
  } state_t;

  state_t               state_r, state_nxt;
  logic [CMD_W-1:0]     cmd_r;
  logic [PIW-1:0]       p_r;
  logic                 pin_r;
  logic [BCNT_W-1:0]    bytes_r;
  logic [ADDR_W-1:0]    addr_r, src_r, idx_r;
  logic [DATA_W-1:0]    wdata_r;
  logic [CW-1:0]        cnt_r, want_r, free_r;
  logic [FW-1:0]        fidx_r, pi_r, clr_r;
  logic [DIVW-1:0]      frame_q_r;
  logic [PSW-1:0]       off_r;
  logic [PHW-1:0]       pa_r, pb_r;
  logic                 dst_r;
  logic [STATUS_W-1:0]  status_r;
  logic [DATA_W-1:0]    rdata_r;
  logic [PROCESSES-1:0] valid_r;
  logic [PS_W-1:0]      page_size_r;

  logic [PSW-1:0]  ps;
  logic            vld;
  logic [PTAW-1:0] pt_base;
  logic [DIVW:0]   want_c;
  logic [PHW-1:0]  phys;
  logic            hit;

  logic            div_go, div_done;
  logic [DIVW-1:0] div_num, div_q;
  logic [PSW-1:0]  div_r;

  logic            fu_we, fu_wdata, fu_rdata;
  logic [FW-1:0]   fu_waddr, fu_raddr;
  logic            pt_we;
  logic [PTAW-1:0] pt_waddr, pt_raddr;
  logic [FW-1:0]   pt_wdata, pt_rdata;
  logic            pc_we;
  logic [PIW-1:0]  pc_waddr, pc_raddr;
  logic [CW-1:0]   pc_wdata, pc_rdata;
  logic            dm_we;
  logic [PHW-1:0]  dm_waddr, dm_raddr;
  logic [DATA_W-1:0] dm_wdata, dm_rdata;

  always_comb begin
    if (page_size_r == '0) begin
      ps = PSW'(1);
    end else if (32'(page_size_r) > MAX_PAGE_BYTES) begin
      ps = PSW'(MAX_PAGE_BYTES);
    end else begin
      ps = PSW'(page_size_r);
    end
  end

  assign vld     = valid_r[p_r];
  assign pt_base = PTAW'(p_r) * PTAW'(FRAMES);
  assign want_c  = (DIVW + 1)'(div_q) + (DIVW + 1)'(div_r != '0);
  assign phys    = PHW'(pt_rdata) * PHW'(ps) + PHW'(off_r);
  assign hit     = DIVW'(pt_rdata) == frame_q_r;

  pmm_div #(.NW(DIVW), .DW(PSW)) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (div_go),
    .num  (div_num),
    .den  (ps),
    .done (div_done),
    .quo  (div_q),
    .rem  (div_r)
  );

  pmm_ram #(.W(1), .D(FRAMES)) u_frame_map (
    .clk(clk), .we(fu_we), .waddr(fu_waddr), .wdata(fu_wdata),
    .raddr(fu_raddr), .rdata(fu_rdata)
  );

  pmm_ram #(.W(FW), .D(PTD)) u_page_table (
    .clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
    .raddr(pt_raddr), .rdata(pt_rdata)
  );

  pmm_ram #(.W(CW), .D(PROCESSES)) u_page_count (
    .clk(clk), .we(pc_we), .waddr(pc_waddr), .wdata(pc_wdata),
    .raddr(pc_raddr), .rdata(pc_rdata)
  );

  pmm_ram #(.W(DATA_W), .D(DD)) u_data (
    .clk(clk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
    .raddr(dm_raddr), .rdata(dm_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    div_go    = 1'b0;
    div_num   = DIVW'(addr_r);
    fu_we     = 1'b0;
    fu_waddr  = fidx_r;
    fu_wdata  = 1'b0;
    fu_raddr  = fidx_r;
    pt_we     = 1'b0;
    pt_waddr  = pt_base + PTAW'(cnt_r);
    pt_wdata  = fidx_r;
    pt_raddr  = pt_base + PTAW'(pi_r);
    pc_we     = 1'b0;
    pc_waddr  = p_r;
    pc_wdata  = cnt_r;
    pc_raddr  = PIW'(in_process_id);
    dm_we     = 1'b0;
    dm_waddr  = pa_r;
    dm_wdata  = wdata_r;
    dm_raddr  = pb_r;
    unique case (state_r)
      S_CLR: begin
        fu_we    = 1'b1;
        fu_waddr = clr_r;
        if (clr_r == FW'(FRAMES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_DONE;
        if (pin_r) begin
          if (cmd_r == CMD_CREATE) begin
            pc_we    = !vld;
            pc_wdata = '0;
          end else if (vld) begin
            case (cmd_r)
              CMD_RESIZE: begin
                div_go    = 1'b1;
                div_num   = DIVW'(bytes_r);
                state_nxt = S_RDIV;
              end
              CMD_DESTROY: state_nxt = S_SHRINK;
              CMD_READ, CMD_WRITE: begin
                div_go    = 1'b1;
                state_nxt = S_LDIV1;
              end
              CMD_COPY: begin
                div_go    = 1'b1;
                div_num   = DIVW'(src_r);
                state_nxt = S_LDIV1;
              end
              default: state_nxt = S_DONE;
            endcase
          end
        end
      end
      S_RDIV: begin
        if (div_done) begin
          if (want_c > (DIVW + 1)'(cnt_r)) begin
            if (want_c - (DIVW + 1)'(cnt_r) > (DIVW + 1)'(free_r)) begin
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_GSCAN;
            end
          end else begin
            state_nxt = S_SHRINK;
          end
        end
      end
      S_GSCAN: state_nxt = S_GCHK;
      S_GCHK: begin
        state_nxt = S_GSCAN;
        if (!fu_rdata) begin
          fu_we    = 1'b1;
          fu_wdata = 1'b1;
          pt_we    = 1'b1;
          if (cnt_r + 1'b1 == want_r) begin
            state_nxt = S_WB;
          end
        end
      end
      S_SHRINK: begin
        if (cnt_r == want_r) begin
          state_nxt = S_WB;
        end else begin
          pt_raddr  = pt_base + PTAW'(cnt_r - 1'b1);
          state_nxt = S_SFREE;
        end
      end
      S_SFREE: begin
        fu_we     = 1'b1;
        fu_waddr  = pt_rdata;
        state_nxt = S_SHRINK;
      end
      S_WB: begin
        pc_we     = 1'b1;
        state_nxt = S_DONE;
      end
      S_LDIV1: begin
        if (div_done) begin
          state_nxt = (cnt_r == '0) ? S_DONE : S_LSRCH;
        end
      end
      S_LSRCH: state_nxt = S_LCMP;
      S_LCMP: begin
        if (hit) begin
          div_go    = 1'b1;
          div_num   = DIVW'(pi_r) * DIVW'(ps) + DIVW'(off_r) + DIVW'(idx_r);
          state_nxt = S_LDIV2;
        end else if (CW'(pi_r) + 1'b1 == cnt_r) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_LSRCH;
        end
      end
      S_LDIV2: begin
        if (div_done) begin
          if (div_q >= DIVW'(cnt_r)) begin
            state_nxt = S_DONE;
          end else begin
            pt_raddr  = pt_base + PTAW'(FW'(div_q));
            state_nxt = S_LFRM;
          end
        end
      end
      S_LFRM: begin
        state_nxt = S_DONE;
        if (cmd_r == CMD_COPY && !dst_r) begin
          div_go    = 1'b1;
          state_nxt = S_LDIV1;
        end else if (cmd_r == CMD_READ) begin
          dm_raddr  = phys;
          state_nxt = S_DRD;
        end else if (cmd_r == CMD_WRITE) begin
          dm_we    = 1'b1;
          dm_waddr = phys;
        end else begin
          state_nxt = S_DRD;
        end
      end
      S_DRD: begin
        // copy: forward the source byte into the destination
        dm_we     = cmd_r == CMD_COPY;
        dm_wdata  = dm_rdata;
        state_nxt = S_DONE;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      valid_r     <= '0;
      free_r      <= CW'(FRAMES);
      page_size_r <= PS_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        page_size_r <= cfg_wdata;
      end
      unique case (state_r)
        S_CLR: clr_r <= clr_r + 1'b1;
        S_IDLE: begin
          cmd_r    <= in_cmd;
          p_r      <= PIW'(in_process_id);
          pin_r    <= 32'(in_process_id) < PROCESSES;
          bytes_r  <= in_byte_count;
          addr_r   <= in_address;
          src_r    <= in_source_address;
          idx_r    <= in_byte_index;
          wdata_r  <= in_write_data;
          dst_r    <= 1'b0;
          status_r <= ST_OK;
          rdata_r  <= '0;
        end
        S_DISP: begin
          cnt_r  <= (pin_r && cmd_r == CMD_CREATE && !vld) ? '0 : pc_rdata;
          want_r <= '0;
          if (!pin_r) begin
            status_r <= ST_NO_PROC;
          end else if (cmd_r == CMD_CREATE) begin
            if (!vld) begin
              valid_r[p_r] <= 1'b1;
            end
          end else if (!vld && cmd_r <= CMD_COPY) begin
            status_r <= ST_NO_PROC;
          end
        end
        S_RDIV: begin
          want_r <= CW'(want_c);
          fidx_r <= '0;
          if (div_done && want_c > (DIVW + 1)'(cnt_r)
              && want_c - (DIVW + 1)'(cnt_r) > (DIVW + 1)'(free_r)) begin
            status_r <= ST_OOM;
          end
        end
        S_GCHK: begin
          fidx_r <= fidx_r + 1'b1;
          if (!fu_rdata) begin
            cnt_r  <= cnt_r + 1'b1;
            free_r <= free_r - 1'b1;
          end
        end
        S_SHRINK: begin
          if (cnt_r != want_r) begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        S_SFREE: free_r <= free_r + 1'b1;
        S_WB: begin
          if (cmd_r == CMD_DESTROY) begin
            valid_r[p_r] <= 1'b0;
          end
        end
        S_LDIV1: begin
          frame_q_r <= div_q;
          off_r     <= div_r;
          pi_r      <= '0;
          if (div_done && cnt_r == '0) begin
            status_r <= ST_NO_PAGE;
          end
        end
        S_LCMP: begin
          pi_r <= pi_r + 1'b1;
          if (!hit && CW'(pi_r) + 1'b1 == cnt_r) begin
            status_r <= ST_NO_PAGE;
          end
        end
        S_LDIV2: begin
          off_r <= div_r;
          if (div_done && div_q >= DIVW'(cnt_r)) begin
            status_r <= ST_NO_PAGE;
          end
        end
        S_LFRM: begin
          if (cmd_r == CMD_COPY && !dst_r) begin
            pb_r  <= phys;
            dst_r <= 1'b1;
          end else begin
            pa_r <= phys;
          end
        end
        S_DRD: rdata_r <= dm_rdata;
        S_DONE: ;
        default: ;
      endcase
    end
  end

  assign busy           = state_r != S_IDLE;
  assign out_strobe     = state_r == S_DONE;
  assign out_status     = status_r;
  assign out_read_data  = rdata_r;
  assign out_pages_held = (pin_r && vld) ? HELD_W'(cnt_r) : '0;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe && !busy)
    else $error("result beat longer than one cycle");

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= CW'(FRAMES))
    else $error("free frame count above frame total");

  a_grow_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_GCHK |-> cnt_r < want_r && free_r != '0)
    else $error("allocation past requested size");

endmodule

### src/pmm_ram.sv
module pmm_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0]  waddr,
  input  logic [W-1:0]                          wdata,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0]  raddr,
  output logic [W-1:0]                          rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/pmm_div.sv
module pmm_div #(
  parameter int NW = 20,
  parameter int DW = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem
);

  localparam int CNTW = $clog2(NW + 1);

  logic            run_r;
  logic            done_r;
  logic [CNTW-1:0] cnt_r;
  logic [NW-1:0]   quo_r;
  logic [DW-1:0]   rem_r;
  logic [DW-1:0]   den_r;
  logic [DW:0]     rem_sh;
  logic            ge;
  logic [DW-1:0]   rem_nxt;
  logic [NW-1:0]   quo_nxt;

  // one quotient bit a cycle, restoring
  always_comb begin
    rem_sh  = {rem_r, quo_r[NW-1]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_nxt = ge ? DW'(rem_sh - {1'b0, den_r}) : DW'(rem_sh);
    quo_nxt = {quo_r[NW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= CNTW'(NW);
        quo_r <= num;
        rem_r <= '0;
        den_r <= den;
      end else if (run_r) begin
        quo_r <= quo_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule
